>>> hw/rtl/ppu_pkg.sv
package ppu_pkg;

   // field widths
   localparam int TICK_W   = 16;
   localparam int LIFE_W   = 24;
   localparam int GRAV_W   = 16;
   localparam int VEL_W    = 48;
   localparam int DIR_W    = 32;
   localparam int COLOR_W  = 32;
   localparam int FADE_W   = 16;
   localparam int POS_W    = 32;
   localparam int TIME_W   = 32;

   // shared multiplier operands and product
   localparam int MUL_A_W  = 41;
   localparam int MUL_B_W  = 25;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   // fade division: 40-bit fractions, 48-bit dividend, 8-bit quotient
   localparam int FRAC_W   = 40;
   localparam int DIVD_W   = 48;
   localparam int QUOT_W   = 8;

   // register port
   localparam int ADDR_W   = 6;
   localparam int DATA_W   = 64;
   localparam int INDEX_W  = 3;

   localparam logic [INDEX_W-1:0] REG_LIFE_TIME  = 3'd0;
   localparam logic [INDEX_W-1:0] REG_GRAVITY    = 3'd1;
   localparam logic [INDEX_W-1:0] REG_VELOCITY   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_DIRECTION  = 3'd3;
   localparam logic [INDEX_W-1:0] REG_COLOR_START = 3'd4;
   localparam logic [INDEX_W-1:0] REG_COLOR_FINAL = 3'd5;
   localparam logic [INDEX_W-1:0] REG_FADE_START = 3'd6;

   localparam logic [LIFE_W-1:0]  LIFE_RESET  = 24'd1024;
   localparam logic [DIR_W-1:0]   DIR_RESET   = 32'd16384;
   localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [LIFE_W-1:0]  life_time;
      logic [GRAV_W-1:0]  gravity;
      logic [VEL_W-1:0]   velocity_xyz;
      logic [DIR_W-1:0]   direction_cos_sin;
      logic [COLOR_W-1:0] color_start;
      logic [COLOR_W-1:0] color_final;
      logic [FADE_W-1:0]  fade_start_fraction;
   } ppu_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ppu_div_stat_type;

endpackage

>>> hw/rtl/ppu_if.sv
interface ppu_req_if;
   import ppu_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [TICK_W-1:0] tick;

   modport source (output valid, mode, tick, input ready);
   modport sink   (input valid, mode, tick, output ready);
endinterface

interface ppu_rsp_if;
   import ppu_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  offset_x;
   logic signed [POS_W-1:0]  offset_y;
   logic signed [POS_W-1:0]  offset_z;
   logic [COLOR_W-1:0]       color_now;
   logic                     stopped;

   modport source (output valid, offset_x, offset_y, offset_z, color_now, stopped,
                   input ready);
   modport sink   (input valid, offset_x, offset_y, offset_z, color_now, stopped,
                   output ready);
endinterface

>>> hw/rtl/ppu_csr.sv
module ppu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ppu_pkg::ADDR_W-1:0]  paddr,
   input  logic [ppu_pkg::DATA_W-1:0]  pwdata,
   output logic [ppu_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output ppu_pkg::ppu_cfg_type        cfg
);
   import ppu_pkg::*;

   ppu_cfg_type        cfg_ff;
   logic [INDEX_W-1:0] index;
   logic               write_en;

   assign pready   = 1'b1;
   assign index    = paddr[ADDR_W-1:ADDR_W-INDEX_W];
   assign write_en = psel & penable & pwrite & pready;
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.life_time           <= LIFE_RESET;
         cfg_ff.gravity             <= '0;
         cfg_ff.velocity_xyz        <= '0;
         cfg_ff.direction_cos_sin   <= DIR_RESET;
         cfg_ff.color_start         <= COLOR_RESET;
         cfg_ff.color_final         <= COLOR_RESET;
         cfg_ff.fade_start_fraction <= '0;
      end else if (write_en) begin
         unique case (index)
            REG_LIFE_TIME:   cfg_ff.life_time           <= pwdata[LIFE_W-1:0];
            REG_GRAVITY:     cfg_ff.gravity             <= pwdata[GRAV_W-1:0];
            REG_VELOCITY:    cfg_ff.velocity_xyz        <= pwdata[VEL_W-1:0];
            REG_DIRECTION:   cfg_ff.direction_cos_sin   <= pwdata[DIR_W-1:0];
            REG_COLOR_START: cfg_ff.color_start         <= pwdata[COLOR_W-1:0];
            REG_COLOR_FINAL: cfg_ff.color_final         <= pwdata[COLOR_W-1:0];
            REG_FADE_START:  cfg_ff.fade_start_fraction <= pwdata[FADE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_LIFE_TIME:   prdata = {{(DATA_W-LIFE_W){1'b0}}, cfg_ff.life_time};
         REG_GRAVITY:     prdata = {{(DATA_W-GRAV_W){1'b0}}, cfg_ff.gravity};
         REG_VELOCITY:    prdata = {{(DATA_W-VEL_W){1'b0}}, cfg_ff.velocity_xyz};
         REG_DIRECTION:   prdata = {{(DATA_W-DIR_W){1'b0}}, cfg_ff.direction_cos_sin};
         REG_COLOR_START: prdata = {{(DATA_W-COLOR_W){1'b0}}, cfg_ff.color_start};
         REG_COLOR_FINAL: prdata = {{(DATA_W-COLOR_W){1'b0}}, cfg_ff.color_final};
         REG_FADE_START:  prdata = {{(DATA_W-FADE_W){1'b0}}, cfg_ff.fade_start_fraction};
         default:         prdata = '0;
      endcase
   end

endmodule

>>> hw/rtl/ppu_mul.sv
module ppu_mul (
   input  logic                               clock,
   input  logic signed [ppu_pkg::MUL_A_W-1:0] a,
   input  logic signed [ppu_pkg::MUL_B_W-1:0] b,
   output logic signed [ppu_pkg::MUL_P_W-1:0] prod
);
   import ppu_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;

   // one registered signed product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule

>>> hw/rtl/ppu_div.sv
module ppu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ppu_pkg::DIVD_W-1:0]  dividend,
   input  logic [ppu_pkg::FRAC_W-1:0]  divisor,
   output ppu_pkg::ppu_div_stat_type   stat,
   output logic [ppu_pkg::QUOT_W-1:0]  quotient
);
   import ppu_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] dsh_ff, dsh_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVD_W:0]   trial;

   // restoring division, one quotient bit per cycle, msb first
   assign trial = {1'b0, rem_ff} - {1'b0, dsh_ff};

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = {{(DIVD_W-FRAC_W-QUOT_W+1){1'b0}}, divisor, {(QUOT_W-1){1'b0}}};
         q_in    = '0;
         cnt_in  = CNT_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIVD_W]) begin
            rem_in = trial[DIVD_W-1:0];
         end
         q_in   = {q_ff[QUOT_W-2:0], ~trial[DIVD_W]};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

>>> hw/rtl/projectile_particle_update.sv
// Projectile particle update. Each req item either restarts the particle
// (mode 1) or advances its elapsed time by tick (mode 0, 1/1024 s units,
// saturating). While the particle lives, its Q16.16 offsets follow
// projectile motion from the Q8.8 speeds, the Q1.14 cos/sin pair and the
// Q8.8 gravity, and past the fade border its RGBA8 colour blends from
// color_start to color_final. Every req item yields exactly one rsp item.
// Each moving advance item past the fade border uses the single registered
// 41x25 multiplier, one issue step and one take step per use, nine times for
// the motion terms and the fade border and once per colour channel, and the
// restoring divider once per channel; an item before the border skips the
// colour work, and a restart or an advance that stops or finds the particle
// stopped skips both. req.ready is high only while the sequencer is idle, so
// an item holds off the next until its result moves to the rsp output
// register; a finished result waits there, so the next item can be accepted
// while it is still pending, and a second result stalls in the response
// state until the first is taken. Registers are written over the APB-style
// port (8-byte stride, pready tied high); the user must write them only while
// the block is idle, which the block itself does not enforce.
module projectile_particle_update (
   input  logic                       clock,
   input  logic                       reset,
   ppu_req_if.sink                    req,
   ppu_rsp_if.source                  rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ppu_pkg::ADDR_W-1:0] paddr,
   input  logic [ppu_pkg::DATA_W-1:0] pwdata,
   output logic [ppu_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import ppu_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_FADE  = 3'd3;
   localparam logic [2:0] S_CHMUL = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   // multiplier operations, issued in this order
   localparam logic [3:0] OP_VXC    = 4'd0;  // vx * cos
   localparam logic [3:0] OP_VYS    = 4'd1;  // vy * sin
   localparam logic [3:0] OP_VZC    = 4'd2;  // vz * cos
   localparam logic [3:0] OP_XE     = 4'd3;  // (vx*cos) * e
   localparam logic [3:0] OP_ZE     = 4'd4;  // (vz*cos) * e
   localparam logic [3:0] OP_YE     = 4'd5;  // (vy*sin) * e
   localparam logic [3:0] OP_GE     = 4'd6;  // gravity * e
   localparam logic [3:0] OP_GEE    = 4'd7;  // (gravity*e) * e
   localparam logic [3:0] OP_BORDER = 4'd8;  // life_time * fade_start_fraction
   localparam logic [3:0] OP_CHAN   = 4'd9;  // |final - start| * num, per channel

   ppu_cfg_type cfg;

   logic [2:0]               state_ff, state_in;
   logic [3:0]               op_ff, op_in;
   logic                     phase_ff, phase_in;
   logic [1:0]               ch_ff, ch_in;
   logic [TIME_W-1:0]        e_ff, e_in;
   logic                     moving_ff, moving_in;
   logic [POS_W-1:0]         pos_ff [3];
   logic [POS_W-1:0]         pos_in [3];
   logic [COLOR_W-1:0]       color_ff, color_in;
   logic [POS_W-1:0]         tx_ff, tx_in, ty_ff, ty_in, tz_ff, tz_in;
   logic [MUL_A_W-1:0]       yv_ff, yv_in;
   logic [FRAC_W-1:0]        g_ff, g_in, bd_ff, bd_in;
   logic [FRAC_W-1:0]        num_ff, num_in, den_ff, den_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]         out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic [COLOR_W-1:0]       out_color_ff, out_color_in;
   logic                     out_stop_ff, out_stop_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   logic                     div_start;
   ppu_div_stat_type         div_stat;
   logic [QUOT_W-1:0]        quotient;

   logic                     accept;
   logic [TIME_W:0]          time_sum;
   logic [LIFE_W-1:0]        e_life;
   logic [FRAC_W:0]          fade_diff;
   logic [7:0]               ch_start, ch_end, ch_mag, ch_value;
   logic                     ch_down;
   logic [MUL_P_W-14:0]      y_diff;   // 53-bit signed y before saturation
   logic                     rsp_free;

   // 53-bit signed value to signed 32, clamped
   function automatic logic [POS_W-1:0] sat32(input logic [52:0] v);
      logic [21:0] top;
      top = v[52:31];
      if (top == '0 || top == '1) begin
         return v[POS_W-1:0];
      end
      return v[52] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   ppu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ppu_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   ppu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod[DIVD_W-1:0]),
      .divisor  (den_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid & req.ready;
   assign rsp_free  = ~rsp_valid_ff | rsp.ready;

   // while moving e < life_time, so its low 24 bits are the whole value
   assign e_life    = e_ff[LIFE_W-1:0];
   assign time_sum  = {1'b0, e_ff} + {{(TIME_W-TICK_W+1){1'b0}}, req.tick};

   // fade border check: e*2^16 - border
   assign fade_diff = {1'b0, e_life, 16'b0} - {1'b0, bd_ff};

   // current colour channel
   assign ch_start = cfg.color_start[{ch_ff, 3'b000} +: 8];
   assign ch_end   = cfg.color_final[{ch_ff, 3'b000} +: 8];
   assign ch_down  = ch_end < ch_start;
   assign ch_mag   = ch_down ? ch_start - ch_end : ch_end - ch_start;
   // quotient never exceeds the channel distance, so no clamp is needed
   assign ch_value = ch_down ? ch_start - quotient : ch_start + quotient;

   // y = floor(vy*sin*e / 2^16) - floor(g*e^2 / 2^13); g*e^2 < 2^64
   assign y_diff = {{12{yv_ff[MUL_A_W-1]}}, yv_ff} - {2'b00, prod[63:13]};

   assign div_start = (state_ff == S_CHMUL) & phase_ff;

   // operand select for the shared multiplier
   always_comb begin
      unique case (op_ff)
         OP_VXC: begin
            mul_a = {{25{cfg.velocity_xyz[15]}}, cfg.velocity_xyz[15:0]};
            mul_b = {{9{cfg.direction_cos_sin[15]}}, cfg.direction_cos_sin[15:0]};
         end
         OP_VYS: begin
            mul_a = {{25{cfg.velocity_xyz[31]}}, cfg.velocity_xyz[31:16]};
            mul_b = {{9{cfg.direction_cos_sin[31]}}, cfg.direction_cos_sin[31:16]};
         end
         OP_VZC: begin
            mul_a = {{25{cfg.velocity_xyz[47]}}, cfg.velocity_xyz[47:32]};
            mul_b = {{9{cfg.direction_cos_sin[15]}}, cfg.direction_cos_sin[15:0]};
         end
         OP_XE: begin
            mul_a = {{9{tx_ff[POS_W-1]}}, tx_ff};
            mul_b = {1'b0, e_life};
         end
         OP_ZE: begin
            mul_a = {{9{tz_ff[POS_W-1]}}, tz_ff};
            mul_b = {1'b0, e_life};
         end
         OP_YE: begin
            mul_a = {{9{ty_ff[POS_W-1]}}, ty_ff};
            mul_b = {1'b0, e_life};
         end
         OP_GE: begin
            mul_a = {25'b0, cfg.gravity};
            mul_b = {1'b0, e_life};
         end
         OP_GEE: begin
            mul_a = {1'b0, g_ff};
            mul_b = {1'b0, e_life};
         end
         OP_BORDER: begin
            mul_a = {17'b0, cfg.life_time};
            mul_b = {9'b0, cfg.fade_start_fraction};
         end
         OP_CHAN: begin
            mul_a = {1'b0, num_ff};
            mul_b = {17'b0, ch_mag};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      ch_in        = ch_ff;
      e_in         = e_ff;
      moving_in    = moving_ff;
      pos_in       = pos_ff;
      color_in     = color_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      tz_in        = tz_ff;
      yv_in        = yv_ff;
      g_in         = g_ff;
      bd_in        = bd_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_color_in = out_color_ff;
      out_stop_in  = out_stop_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.mode) begin
                  // restart: back to time zero, colour kept
                  e_in      = '0;
                  moving_in = 1'b1;
                  pos_in[0] = '0;
                  pos_in[1] = '0;
                  pos_in[2] = '0;
                  state_in  = S_RESP;
               end else begin
                  e_in     = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            // lifetime reached: freeze; time keeps accumulating
            if (moving_ff && (e_ff < {{(TIME_W-LIFE_W){1'b0}}, cfg.life_time})) begin
               op_in    = OP_VXC;
               phase_in = 1'b0;
               state_in = S_MUL;
            end else begin
               moving_in = 1'b0;
               state_in  = S_RESP;
            end
         end
         S_MUL: begin
            // phase 0 issues, phase 1 takes the registered product
            phase_in = ~phase_ff;
            if (phase_ff) begin
               unique case (op_ff)
                  OP_VXC:    tx_in     = prod[POS_W-1:0];
                  OP_VYS:    ty_in     = prod[POS_W-1:0];
                  OP_VZC:    tz_in     = prod[POS_W-1:0];
                  OP_XE:     pos_in[0] = sat32({{3{prod[MUL_P_W-1]}}, prod[MUL_P_W-1:16]});
                  OP_ZE:     pos_in[2] = sat32({{3{prod[MUL_P_W-1]}}, prod[MUL_P_W-1:16]});
                  OP_YE:     yv_in     = prod[56:16];
                  OP_GE:     g_in      = prod[FRAC_W-1:0];
                  OP_GEE:    pos_in[1] = sat32(y_diff);
                  OP_BORDER: bd_in     = prod[FRAC_W-1:0];
                  default: ;
               endcase
               if (op_ff == OP_BORDER) begin
                  state_in = S_FADE;
               end else begin
                  op_in = op_ff + 1'b1;
               end
            end
         end
         S_FADE: begin
            // before the border the colour holds
            if (fade_diff[FRAC_W]) begin
               state_in = S_RESP;
            end else begin
               num_in   = fade_diff[FRAC_W-1:0];
               den_in   = {cfg.life_time, 16'b0} - bd_ff;
               op_in    = OP_CHAN;
               phase_in = 1'b0;
               ch_in    = '0;
               state_in = S_CHMUL;
            end
         end
         S_CHMUL: begin
            phase_in = ~phase_ff;
            if (phase_ff) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               color_in[{ch_ff, 3'b000} +: 8] = ch_value;
               if (ch_ff == 2'd3) begin
                  state_in = S_RESP;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = S_CHMUL;
               end
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               out_x_in     = pos_ff[0];
               out_y_in     = pos_ff[1];
               out_z_in     = pos_ff[2];
               out_color_in = color_ff;
               out_stop_in  = ~moving_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         e_ff         <= '0;
         moving_ff    <= 1'b1;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         pos_ff[2]    <= '0;
         color_ff     <= COLOR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         e_ff         <= e_in;
         moving_ff    <= moving_in;
         pos_ff       <= pos_in;
         color_ff     <= color_in;
      end
      op_ff        <= op_in;
      phase_ff     <= phase_in;
      ch_ff        <= ch_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      tz_ff        <= tz_in;
      yv_ff        <= yv_in;
      g_ff         <= g_in;
      bd_ff        <= bd_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_z_ff     <= out_z_in;
      out_color_ff <= out_color_in;
      out_stop_ff  <= out_stop_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.offset_x  = out_x_ff;
   assign rsp.offset_y  = out_y_ff;
   assign rsp.offset_z  = out_z_ff;
   assign rsp.color_now = out_color_ff;
   assign rsp.stopped   = out_stop_ff;

`ifndef NO_ASSERTIONS
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.mode |=> e_ff == '0 && moving_ff && state_ff == S_RESP)
      else $error("restart did not clear the particle");

   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      !moving_ff && !(accept && req.mode) |=> !moving_ff)
      else $error("stopped particle resumed without restart");

   a_mul_in_life: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> e_ff < {{(TIME_W-LIFE_W){1'b0}}, cfg.life_time})
      else $error("motion computed past the lifetime");

   a_div_only_moving: assert property (@(posedge clock) disable iff (reset)
      div_start |-> moving_ff && !div_stat.busy)
      else $error("fade division started out of turn");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");
`endif

endmodule

>>> verif/tb.sv
// Projectile particle update: self-checking bench.
// A shadow copy of the particle state and registers predicts one update per
// accepted req item; every rsp item is matched field by field against the
// oldest prediction. Registers are only touched once every update is back.
module tb;
   import ppu_pkg::*;

   localparam logic MODE_ADVANCE = 1'b0;
   localparam logic MODE_RESTART = 1'b1;

   // index past the last register, must be ignored by the block
   localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;

   localparam int IDLE_PCT        = 26;
   localparam int RSP_HOLD_CYCLES = 400;   // long output stall
   localparam int QUIET_LIMIT     = 4000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES    = 100;   // settle time after the final drain
   localparam int RANDOM_PHASES   = 13;
   localparam int PHASE_ITEMS     = 60;

   typedef struct packed {
      logic signed [POS_W-1:0] offset_x;
      logic signed [POS_W-1:0] offset_y;
      logic signed [POS_W-1:0] offset_z;
      logic [COLOR_W-1:0]      color_now;
      logic                    stopped;
   } particle_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   ppu_req_if req_bus ();
   ppu_rsp_if rsp_bus ();

   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   projectile_particle_update dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the block: registers and particle state
   ppu_cfg_type              live_cfg;
   logic [TIME_W-1:0]        flight_time;
   logic                     in_flight;
   logic signed [POS_W-1:0]  offset_now [3];
   logic [COLOR_W-1:0]       color_held;

   particle_update_type updates_due [$];

   bit idle_enable = 1'b1;
   bit rsp_hold_request = 1'b0;

   int mismatch_count = 0;
   int items_sent = 0;
   int updates_checked = 0;
   int reg_writes = 0;
   int quiet_cycles = 0;

   function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[POS_W-1:0];
   endfunction

   // One particle step; updates the shadow state and returns the expected rsp.
   function automatic particle_update_type advance_particle(input logic mode,
                                                            input logic [TICK_W-1:0] tick);
      logic [TIME_W:0]    sum;
      logic signed [63:0] cos_q, sin_q, vx, vy, vz, et, fall;
      logic [127:0]       drop;
      logic [63:0]        border, now_t, num, den, mag;
      logic [COLOR_W-1:0] blend;
      int                 a, b, d, v;
      particle_update_type r;
      if (mode == MODE_RESTART) begin
         flight_time = '0;
         offset_now[0] = '0;
         offset_now[1] = '0;
         offset_now[2] = '0;
         in_flight = 1'b1;
      end else begin
         sum = flight_time + tick;
         flight_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
         if (flight_time >= live_cfg.life_time) in_flight = 1'b0;
         if (in_flight) begin
            cos_q = $signed(live_cfg.direction_cos_sin[15:0]);
            sin_q = $signed(live_cfg.direction_cos_sin[31:16]);
            vx = $signed(live_cfg.velocity_xyz[15:0]);
            vy = $signed(live_cfg.velocity_xyz[31:16]);
            vz = $signed(live_cfg.velocity_xyz[47:32]);
            et = 64'(flight_time);
            // fall = g*t^2/2^13, pinned at 2^48 once g*t^2 passes 2^60
            drop = 128'(live_cfg.gravity) * flight_time * flight_time;
            fall = (drop > (128'd1 << 60)) ? (64'sd1 <<< 48) : 64'(drop >> 13);
            offset_now[0] = clamp_pos((vx * cos_q * et) >>> 16);
            offset_now[1] = clamp_pos(((vy * sin_q * et) >>> 16) - fall);
            offset_now[2] = clamp_pos((vz * cos_q * et) >>> 16);
            // fade: all in 2^-16 tick units
            border = 64'(live_cfg.life_time) * live_cfg.fade_start_fraction;
            now_t = 64'(flight_time) << 16;
            den = (64'(live_cfg.life_time) << 16) - border;
            if (border <= now_t && den != 0) begin
               num = now_t - border;
               blend = '0;
               for (int ch = 0; ch < 4; ch++) begin
                  a = live_cfg.color_start[8*ch +: 8];
                  b = live_cfg.color_final[8*ch +: 8];
                  d = b - a;
                  mag = 64'(d < 0 ? -d : d) * num / den;
                  v = (d < 0) ? a - int'(mag) : a + int'(mag);
                  if (v < 0) v = 0;
                  if (v > 255) v = 255;
                  blend[8*ch +: 8] = 8'(v);
               end
               color_held = blend;
            end
         end
      end
      r.offset_x = offset_now[0];
      r.offset_y = offset_now[1];
      r.offset_z = offset_now[2];
      r.color_now = color_held;
      r.stopped = !in_flight;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Drivers. Every task is entered right after a rising edge.
   // ------------------------------------------------------------------

   // Offer one item, hold it until taken, then predict its update.
   task automatic send_item(input logic mode, input logic [TICK_W-1:0] tick);
      while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.tick <= tick;
      do @(posedge clock); while (!req_bus.ready);
      updates_due.push_back(advance_particle(mode, tick));
      items_sent++;
   endtask

   // Sender pause: stop offering until every update is back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (updates_due.size() != 0);
   endtask

   // APB write: setup, then access; lands at the edge with pready high.
   // Only issued with the block idle, so it drains first.
   task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [DATA_W-1:0] value);
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(index) << 3;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      case (index)
         REG_LIFE_TIME:   live_cfg.life_time = value[LIFE_W-1:0];
         REG_GRAVITY:     live_cfg.gravity = value[GRAV_W-1:0];
         REG_VELOCITY:    live_cfg.velocity_xyz = value[VEL_W-1:0];
         REG_DIRECTION:   live_cfg.direction_cos_sin = value[DIR_W-1:0];
         REG_COLOR_START: live_cfg.color_start = value[COLOR_W-1:0];
         REG_COLOR_FINAL: live_cfg.color_final = value[COLOR_W-1:0];
         REG_FADE_START:  live_cfg.fade_start_fraction = value[FADE_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   task automatic write_config(input ppu_cfg_type c);
      write_reg(REG_LIFE_TIME, DATA_W'(c.life_time));
      write_reg(REG_GRAVITY, DATA_W'(c.gravity));
      write_reg(REG_VELOCITY, DATA_W'(c.velocity_xyz));
      write_reg(REG_DIRECTION, DATA_W'(c.direction_cos_sin));
      write_reg(REG_COLOR_START, DATA_W'(c.color_start));
      write_reg(REG_COLOR_FINAL, DATA_W'(c.color_final));
      write_reg(REG_FADE_START, DATA_W'(c.fade_start_fraction));
   endtask

   // Random setting; lifetimes spread over short, mid and full range,
   // direction half the time a real cos/sin pair, else raw bits.
   function automatic ppu_cfg_type random_config();
      ppu_cfg_type c;
      real ang;
      case ($urandom_range(0, 6))
         0: c.life_time = 24'($urandom_range(1, 64));
         1: c.life_time = 24'($urandom_range(1, 4096));
         2, 3: c.life_time = 24'($urandom_range(1, 1 << 20));
         4: c.life_time = 24'($urandom);
         5: c.life_time = '1;
         default: c.life_time = $urandom_range(0, 3) == 0 ? 24'd0 : 24'd1;
      endcase
      case ($urandom_range(0, 3))
         0: c.gravity = '0;
         1: c.gravity = '1;
         2: c.gravity = 16'($urandom_range(0, 255));
         default: c.gravity = 16'($urandom);
      endcase
      c.velocity_xyz = {16'($urandom), 32'($urandom)};
      if ($urandom_range(0, 1) == 0) begin
         c.direction_cos_sin = $urandom;
      end else begin
         ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
         c.direction_cos_sin = {16'(int'($sin(ang) * 16384.0)),
                                16'(int'($cos(ang) * 16384.0))};
      end
      c.color_start = $urandom;
      c.color_final = $urandom;
      case ($urandom_range(0, 3))
         0: c.fade_start_fraction = '0;
         1: c.fade_start_fraction = '1;
         default: c.fade_start_fraction = 16'($urandom);
      endcase
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Power-on registers: still particle, white, 1024-tick life.
   task automatic test_reset_values();
      send_item(MODE_ADVANCE, 16'h0000);
      send_item(MODE_ADVANCE, 16'h0001);
      send_item(MODE_ADVANCE, 16'd1000);
      send_item(MODE_ADVANCE, 16'd23);     // hits the lifetime exactly
      send_item(MODE_ADVANCE, 16'h0000);   // frozen
      send_item(MODE_RESTART, 16'hFFFF);   // tick ignored on restart
      send_item(MODE_ADVANCE, 16'h8000);   // overshoots the lifetime
   endtask

   // Extreme speeds, angle and gravity, fade border edges, zero and
   // one-tick lifetimes, a write to an unused index.
   task automatic test_extremes();
      ppu_cfg_type c;
      c.life_time = '1;
      c.gravity = '1;
      c.velocity_xyz = {16'h8000, 16'h7FFF, 16'h7FFF};
      c.direction_cos_sin = {16'h7FFF, 16'h8000};
      c.color_start = 32'h00FF_00FF;
      c.color_final = 32'hFF00_FF00;
      c.fade_start_fraction = 16'h8000;
      write_config(c);
      send_item(MODE_RESTART, 16'h0000);
      send_item(MODE_ADVANCE, 16'h0000);
      send_item(MODE_ADVANCE, 16'h0001);
      repeat (3) send_item(MODE_ADVANCE, 16'hFFFF);   // offsets saturate
      write_reg(REG_UNUSED, '1);
      send_item(MODE_ADVANCE, 16'h0100);
      write_reg(REG_FADE_START, '0);                   // fade from time zero
      send_item(MODE_ADVANCE, 16'h1234);
      write_reg(REG_LIFE_TIME, '0);                    // zero lifetime
      send_item(MODE_ADVANCE, 16'h0000);
      send_item(MODE_RESTART, 16'hFFFF);
      send_item(MODE_ADVANCE, 16'h0000);
      write_reg(REG_LIFE_TIME, 64'd1);                 // one-tick lifetime
      send_item(MODE_RESTART, 16'h0000);
      send_item(MODE_ADVANCE, 16'h0000);
      send_item(MODE_ADVANCE, 16'h0001);
      write_reg(REG_FADE_START, '1);                   // fade only at the end
      write_reg(REG_LIFE_TIME, 64'd16);
      send_item(MODE_RESTART, 16'h0000);
      send_item(MODE_ADVANCE, 16'd15);
      send_item(MODE_ADVANCE, 16'd1);
   endtask

   // One long flight with big ticks: runs into the pinned gravity term
   // (g*t^2 past 2^60) before the lifetime ends.
   task automatic test_long_flight();
      ppu_cfg_type c;
      c = random_config();
      c.life_time = 24'h50_0000;
      c.gravity = '1;
      write_config(c);
      send_item(MODE_RESTART, 16'($urandom));
      while (in_flight) send_item(MODE_ADVANCE, 16'($urandom_range(49152, 65535)));
      send_item(MODE_ADVANCE, 16'hFFFF);
   endtask

   // Receiver holds off for a long stretch while items keep coming, so the
   // block fills and has to stall req.
   task automatic test_output_stall();
      ppu_cfg_type c;
      c = random_config();
      c.life_time = '1;
      write_config(c);
      rsp_hold_request = 1'b1;
      send_item(MODE_RESTART, 16'($urandom));
      repeat (30) send_item(MODE_ADVANCE, 16'($urandom_range(0, 4096)));
   endtask

   // Random phases: new setting each time, mostly flights with ticks sized
   // to the lifetime, with raw ticks, tiny ticks and restarts mixed in.
   // One phase runs with no idling on either side.
   task automatic test_random_flights();
      int hint;
      logic [TICK_W-1:0] tick;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_config(random_config());
         idle_enable = (p != 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            hint = int'(live_cfg.life_time) / 10 + 1;
            if (hint > 65535) hint = 65535;
            if ((!in_flight && $urandom_range(0, 2) == 0) || $urandom_range(99) < 5) begin
               send_item(MODE_RESTART, 16'($urandom));
            end else begin
               case ($urandom_range(0, 9))
                  0, 1: tick = 16'($urandom);
                  2: tick = 16'($urandom_range(0, 2));
                  default: tick = 16'($urandom_range(0, hint));
               endcase
               send_item(MODE_ADVANCE, tick);
            end
         end
      end
      idle_enable = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Receiver: random ready, or a long hold-off on request.
   // ------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= !(idle_enable && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Checker: each rsp item against the oldest prediction.
   always @(posedge clock) begin
      particle_update_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         updates_checked++;
         if (updates_due.size() == 0) begin
            $error("rsp item with no req item outstanding");
            mismatch_count++;
         end else begin
            want = updates_due.pop_front();
            if (rsp_bus.offset_x !== want.offset_x) begin
               $error("offset_x: expected %0d, got %0d", want.offset_x, rsp_bus.offset_x);
               mismatch_count++;
            end
            if (rsp_bus.offset_y !== want.offset_y) begin
               $error("offset_y: expected %0d, got %0d", want.offset_y, rsp_bus.offset_y);
               mismatch_count++;
            end
            if (rsp_bus.offset_z !== want.offset_z) begin
               $error("offset_z: expected %0d, got %0d", want.offset_z, rsp_bus.offset_z);
               mismatch_count++;
            end
            if (rsp_bus.color_now !== want.color_now) begin
               $error("color_now: expected %08h, got %08h", want.color_now, rsp_bus.color_now);
               mismatch_count++;
            end
            if (rsp_bus.stopped !== want.stopped) begin
               $error("stopped: expected %0b, got %0b", want.stopped, rsp_bus.stopped);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too long with nothing moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: %0d updates still due", updates_due.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_ADVANCE;
      req_bus.tick <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;

      // power-on state of the shadow
      live_cfg.life_time = LIFE_RESET;
      live_cfg.gravity = '0;
      live_cfg.velocity_xyz = '0;
      live_cfg.direction_cos_sin = DIR_RESET;
      live_cfg.color_start = COLOR_RESET;
      live_cfg.color_final = COLOR_RESET;
      live_cfg.fade_start_fraction = '0;
      flight_time = '0;
      in_flight = 1'b1;
      offset_now[0] = '0;
      offset_now[1] = '0;
      offset_now[2] = '0;
      color_held = COLOR_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_extremes();
      test_long_flight();
      test_output_stall();
      test_random_flights();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items (advance, restart, stop, fade, saturation), %0d updates checked,",
               items_sent, updates_checked);
      $display("%0d register writes across %0d settings, with stalls on both channels.",
               reg_writes, RANDOM_PHASES + 3);
      if (mismatch_count == 0 && updates_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
